/* rtl/wsr_pkg.sv */
// Package for the WebSocket message reassembler.
// Holds the event and result types, status and opcode codes and reset constants.
// No dependencies.
package wsr_pkg;

  // Default largest receive buffer the block is built for, in bytes.
  localparam int unsigned MAX_BUFFER_BYTES_DEFAULT = 65536;

  // Receive buffer size after reset, in bytes.
  localparam logic [16:0] CAPACITY_RESET = 17'd4096;

  // Event kinds.
  localparam logic FUNC_READ       = 1'b0;
  localparam logic FUNC_LINK_RESET = 1'b1;

  // Frame opcodes that the block acts on.
  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;

  // Result status codes.
  localparam logic [2:0] ST_ACCUM     = 3'd0;
  localparam logic [2:0] ST_DELIVERED = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_STRAY     = 3'd3;
  localparam logic [2:0] ST_DISCARD   = 3'd4;
  localparam logic [2:0] ST_IGNORED   = 3'd5;
  localparam logic [2:0] ST_RESET     = 3'd6;

  // One input event.
  typedef struct packed {
    logic        func;
    logic [16:0] byte_count;
    logic [3:0]  opcode;
    logic        fin;
    logic [30:0] frame_payload_len;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  status;
    logic [16:0] message_length;
    logic [15:0] write_offset;
    logic [31:0] drop_total;
    logic [31:0] delivered_count;
    logic [31:0] delivered_bytes;
    logic        message_open;
    logic        discard_mode;
  } result_t;

endpackage

/* rtl/wsr_engine.sv */
// Reassembly state and the combinational step logic of the message reassembler.
// Computes the result of one event and updates the state when the step is taken.
// Depends on wsr_pkg.
module wsr_engine #(
  parameter int unsigned MAX_BUFFER_BYTES = wsr_pkg::MAX_BUFFER_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  wsr_pkg::item_t   item,
  input  logic [16:0]      capacity,
  output wsr_pkg::result_t result
);

  localparam logic [31:0] MAX_BYTES = 32'(MAX_BUFFER_BYTES);

  // Reassembly and session state.
  logic [16:0] bytes_held;
  logic [30:0] frame_remaining;
  logic        discarding;
  logic        assembling;
  logic [31:0] drop_counter;
  logic [31:0] session_messages;
  logic [31:0] session_bytes;

  logic [16:0] bytes_held_next;
  logic [30:0] frame_remaining_next;
  logic        discarding_next;
  logic        assembling_next;
  logic [31:0] drop_counter_next;
  logic [31:0] session_messages_next;
  logic [31:0] session_bytes_next;

  logic [16:0] cap_floor;
  logic [16:0] cap;
  logic [16:0] room;
  logic [16:0] n;
  logic [30:0] n_wide;
  logic [30:0] frame_start;
  logic [30:0] frame_after;
  logic        done;
  logic [16:0] held_sum;
  logic [31:0] drop_inc;
  logic        is_data;
  logic        assembling_eff;

  // Effective capacity, free space and the clamped byte count.
  always_comb begin
    cap_floor = (capacity == 17'd0) ? 17'd1 : capacity;
    cap       = ({15'd0, cap_floor} > MAX_BYTES) ? MAX_BYTES[16:0] : cap_floor;
    room      = (bytes_held < cap) ? (cap - bytes_held) : 17'd0;
    n         = (item.byte_count < room) ? item.byte_count : room;
    n_wide    = {14'd0, n};
  end

  // Frame bookkeeping: a new frame starts from its announced length, or from the clamped byte count if larger.
  always_comb begin
    if (frame_remaining == 31'd0) begin
      frame_start = (item.frame_payload_len > n_wide) ? item.frame_payload_len : n_wide;
    end else begin
      frame_start = frame_remaining;
    end
    frame_after = frame_start - ((n_wide < frame_start) ? n_wide : frame_start);
    done        = item.fin && (frame_after == 31'd0);
    held_sum    = bytes_held + n;
    drop_inc    = (drop_counter == '1) ? drop_counter : (drop_counter + 32'd1);
    is_data     = (item.opcode == wsr_pkg::OP_CONT) || (item.opcode == wsr_pkg::OP_TEXT) ||
                  (item.opcode == wsr_pkg::OP_BINARY);
    assembling_eff = (item.opcode != wsr_pkg::OP_CONT) ? !done : assembling;
  end

  // Next state and result of one event.
  always_comb begin
    bytes_held_next       = bytes_held;
    frame_remaining_next  = frame_remaining;
    discarding_next       = discarding;
    assembling_next       = assembling;
    drop_counter_next     = drop_counter;
    session_messages_next = session_messages;
    session_bytes_next    = session_bytes;
    result.status         = wsr_pkg::ST_IGNORED;
    result.message_length = 17'd0;
    result.write_offset   = bytes_held[15:0];

    if (item.func == wsr_pkg::FUNC_LINK_RESET) begin
      bytes_held_next       = 17'd0;
      frame_remaining_next  = 31'd0;
      discarding_next       = 1'b0;
      assembling_next       = 1'b0;
      session_messages_next = 32'd0;
      session_bytes_next    = 32'd0;
      result.status         = wsr_pkg::ST_RESET;
      result.write_offset   = 16'd0;
    end else if (n == 17'd0) begin
      result.status = wsr_pkg::ST_IGNORED;
    end else if (item.opcode == wsr_pkg::OP_CLOSE) begin
      bytes_held_next       = 17'd0;
      frame_remaining_next  = 31'd0;
      discarding_next       = 1'b0;
      assembling_next       = 1'b0;
      session_messages_next = 32'd0;
      session_bytes_next    = 32'd0;
      result.status         = wsr_pkg::ST_RESET;
    end else if (!is_data) begin
      result.status = wsr_pkg::ST_IGNORED;
    end else begin
      frame_remaining_next = frame_after;
      if (discarding) begin
        // Swallow the rest of a dropped message.
        if (done) begin
          discarding_next = 1'b0;
        end
        result.status = wsr_pkg::ST_DISCARD;
      end else begin
        assembling_next = assembling_eff;
        if ((item.opcode == wsr_pkg::OP_CONT) && !assembling_eff) begin
          // Continuation with no message open.
          drop_counter_next = drop_inc;
          if (!done) begin
            discarding_next = 1'b1;
          end
          result.status = wsr_pkg::ST_STRAY;
        end else if (done) begin
          result.message_length = held_sum;
          session_messages_next = session_messages + 32'd1;
          session_bytes_next    = session_bytes + {15'd0, held_sum};
          bytes_held_next       = 17'd0;
          assembling_next       = 1'b0;
          result.status         = wsr_pkg::ST_DELIVERED;
        end else if (held_sum == cap) begin
          // Buffer full before the message ended.
          drop_counter_next = drop_inc;
          bytes_held_next   = 17'd0;
          assembling_next   = 1'b0;
          discarding_next   = 1'b1;
          result.status     = wsr_pkg::ST_OVERFLOW;
        end else begin
          bytes_held_next = held_sum;
          result.status   = wsr_pkg::ST_ACCUM;
        end
      end
    end

    result.drop_total      = drop_counter_next;
    result.delivered_count = session_messages_next;
    result.delivered_bytes = session_bytes_next;
    result.message_open    = assembling_next;
    result.discard_mode    = discarding_next;
  end

  // State registers, updated when an event is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_held       <= 17'd0;
      frame_remaining  <= 31'd0;
      discarding       <= 1'b0;
      assembling       <= 1'b0;
      drop_counter     <= 32'd0;
      session_messages <= 32'd0;
      session_bytes    <= 32'd0;
    end else if (step) begin
      bytes_held       <= bytes_held_next;
      frame_remaining  <= frame_remaining_next;
      discarding       <= discarding_next;
      assembling       <= assembling_next;
      drop_counter     <= drop_counter_next;
      session_messages <= session_messages_next;
      session_bytes    <= session_bytes_next;
    end
  end

  // A dropped message being swallowed is never also being assembled.
  assert property (@(posedge clk) disable iff (rst) !(discarding && assembling))
    else $error("discarding and assembling both set");

  // Held bytes only exist inside an open message.
  assert property (@(posedge clk) disable iff (rst) (bytes_held != 17'd0) |-> assembling)
    else $error("bytes held with no message open");

  // A delivery empties the buffer.
  assert property (@(posedge clk) disable iff (rst)
    (step && (result.status == wsr_pkg::ST_DELIVERED)) |=> (bytes_held == 17'd0))
    else $error("buffer not emptied after delivery");

  // The drop count never goes down.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (drop_counter >= $past(drop_counter)))
    else $error("drop count decreased");

endmodule

/* rtl/websocket_message_reassembler.sv */
// Top level of the WebSocket message reassembler: channels, input and result registers.
// Depends on wsr_pkg and wsr_engine.
//
// Usage: each event is offered on the input channel (in_valid/in_ready with func,
// byte_count, opcode, fin and frame_payload_len). Every accepted event produces
// exactly one result on the output channel (out_valid/out_ready). The receive
// buffer size is written through the configuration channel (cfg_valid/cfg_ready,
// buffer_capacity), which is always ready; write it only while no event is in flight.
// Each accepted event is held in the input register, and its result is then offered
// from the result register; it is taken at a rising edge with out_ready high.
// Throughput: one event per cycle while out_ready stays high. The step logic between
// the input register and the result register updates the reassembly state as the
// result is registered, so the next event can follow at once.
// When the receiver stalls, the result register holds its item and the input
// register holds one more event; in_ready then drops until out_ready returns.
// Reset (rst, synchronous) empties both registers, clears all state and counters,
// and sets the buffer capacity to 4096 bytes. No clearing pass is needed.
module websocket_message_reassembler #(
  parameter int unsigned MAX_BUFFER_BYTES = wsr_pkg::MAX_BUFFER_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] buffer_capacity,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [16:0] byte_count,
  input  logic [3:0]  opcode,
  input  logic        fin,
  input  logic [30:0] frame_payload_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [16:0] message_length,
  output logic [15:0] write_offset,
  output logic [31:0] drop_total,
  output logic [31:0] delivered_count,
  output logic [31:0] delivered_bytes,
  output logic        message_open,
  output logic        discard_mode
);

  logic             in_full;
  wsr_pkg::item_t   in_item;
  logic             out_full;
  wsr_pkg::result_t out_res;
  wsr_pkg::result_t step_res;
  logic [16:0]      capacity;
  logic             advance;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= wsr_pkg::CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= buffer_capacity;
    end
  end

  // An event moves on when the result register is free or being emptied.
  assign advance  = in_full && (!out_full || out_ready);
  assign in_ready = !in_full || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item.func              <= func;
      in_item.byte_count        <= byte_count;
      in_item.opcode            <= opcode;
      in_item.fin               <= fin;
      in_item.frame_payload_len <= frame_payload_len;
    end
  end

  wsr_engine #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .item     (in_item),
    .capacity (capacity),
    .result   (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign out_valid       = out_full;
  assign status          = out_res.status;
  assign message_length  = out_res.message_length;
  assign write_offset    = out_res.write_offset;
  assign drop_total      = out_res.drop_total;
  assign delivered_count = out_res.delivered_count;
  assign delivered_bytes = out_res.delivered_bytes;
  assign message_open    = out_res.message_open;
  assign discard_mode    = out_res.discard_mode;

endmodule
